// ===== sv/yaw_pitch_view_matrix_assert.svh =====
`ifndef YAW_PITCH_VIEW_MATRIX_ASSERT_SVH
`define YAW_PITCH_VIEW_MATRIX_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle.
`define YPVM_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("ypvm check failed");
// Check that a condition implies a consequence in the next cycle.
`define YPVM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("ypvm check failed");
`endif

// ===== sv/ypvm_pkg.sv =====
package ypvm_pkg;
  localparam int unsigned TabLen = 24;
  localparam logic signed [31:0] GainQ30 = 32'sd652032874;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam logic [14:0] LimitReset = 15'd16199;
  localparam logic [14:0] LimitMax = 15'd16384;

  typedef enum logic {OP_ADD = 1'b0, OP_SET = 1'b1} op_e;

  // Angles settled by the front end, with the position, handed to the back end.
  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } job_t;

  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] rz;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic signed [31:0] tr;
    logic signed [31:0] tu;
    logic signed [31:0] tb;
  } res_t;

  function automatic logic signed [31:0] atan_q32(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd536870912;  5'd1: r = 32'sd316933406;
      5'd2: r = 32'sd167458907;  5'd3: r = 32'sd85004756;
      5'd4: r = 32'sd42667331;   5'd5: r = 32'sd21354465;
      5'd6: r = 32'sd10679838;   5'd7: r = 32'sd5340245;
      5'd8: r = 32'sd2670163;    5'd9: r = 32'sd1335086;
      5'd10: r = 32'sd667544;    5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;    5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41721;     5'd15: r = 32'sd20860;
      5'd16: r = 32'sd10430;     5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2607;      5'd19: r = 32'sd1303;
      5'd20: r = 32'sd651;       5'd21: r = 32'sd325;
      5'd22: r = 32'sd162;       5'd23: r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] clamp14(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd16384) r = OneQ14;
    else if (v < -36'sd16384) r = -OneQ14;
    else r = v[15:0];
    return r;
  endfunction
endpackage

// ===== sv/ypvm_front.sv =====
module ypvm_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic                     op_i,
  input  logic signed [15:0]       yaw_i,
  input  logic signed [15:0]       pitch_i,
  input  logic signed [31:0]       px_i,
  input  logic signed [31:0]       py_i,
  input  logic signed [31:0]       pz_i,
  input  logic [14:0]              limit_i,
  output logic                     job_valid_o,
  input  logic                     job_ready_i,
  output ypvm_pkg::job_t           job_o
);
  logic signed [15:0] yaw_q, yaw_d, pitch_q, pitch_d;
  logic signed [16:0] psum, lim;
  ypvm_pkg::job_t job_q;
  logic valid_q;
  logic take;

  assign full = valid_q && !job_ready_i;
  assign take = push && !full;
  assign lim = (limit_i > ypvm_pkg::LimitMax) ? 17'sd16384 : $signed({2'b00, limit_i});

  always_comb begin
    if (ypvm_pkg::op_e'(op_i) == ypvm_pkg::OP_SET) begin
      yaw_d = yaw_i;
      psum = 17'(pitch_i);
    end else begin
      yaw_d = yaw_q + yaw_i;
      psum = 17'(pitch_q) + 17'(pitch_i);
    end
    if (psum > lim) pitch_d = lim[15:0];
    else if (psum < -lim) pitch_d = 16'(-lim);
    else pitch_d = psum[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q <= '0;
      pitch_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (take) begin
        yaw_q <= yaw_d;
        pitch_q <= pitch_d;
        valid_q <= 1'b1;
      end else if (job_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= '{yaw: yaw_d, pitch: pitch_d, px: px_i, py: py_i, pz: pz_i};
  end

  assign job_valid_o = valid_q;
  assign job_o = job_q;
endmodule

// ===== sv/ypvm_back.sv =====
module ypvm_back #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  ypvm_pkg::job_t       job_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output ypvm_pkg::res_t       res_o
);
  typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_MUL, S_DOT, S_DONE} state_e;
  localparam int unsigned IW = $clog2(CordicSteps + 1);

  state_e state_q;
  logic [IW-1:0] it_q;
  logic [3:0] m_q;
  logic signed [33:0] xa_q, ya_q, xb_q, yb_q;
  logic signed [32:0] za_q, zb_q;
  logic nega_q, negb_q;
  logic signed [15:0] sy, cy, sp, cp;
  logic signed [15:0] ux_q, uz_q, bx_q, bz_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [49:0] acc_q;
  logic signed [15:0] ma;
  logic signed [31:0] mb;
  logic signed [47:0] prod;
  logic signed [31:0] tr_q, tu_q, tb_q;
  logic signed [33:0] dxa, dya, dxb, dyb;
  logic signed [32:0] at;
  logic [4:0] it5;
  logic signed [49:0] tsum;

  function automatic logic signed [15:0] fin(input logic signed [33:0] v, input logic n);
    logic signed [15:0] r;
    r = ypvm_pkg::clamp14(36'((v + 34'sd32768) >>> 16));
    return n ? -r : r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] d);
    logic signed [49:0] v;
    v = (-d + 50'sd8192) >>> 14;
    if (v > 50'sd2147483647) return 32'h7fffffff;
    if (v < -50'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  assign it5 = 5'(it_q);
  assign at = 33'(ypvm_pkg::atan_q32(it5));
  assign dxa = ya_q >>> it_q;
  assign dya = xa_q >>> it_q;
  assign dxb = yb_q >>> it_q;
  assign dyb = xb_q >>> it_q;

  assign sy = fin(ya_q, nega_q);
  assign cy = fin(xa_q, nega_q);
  assign sp = fin(yb_q, negb_q);
  assign cp = fin(xb_q, negb_q);

  // One shared multiplier; m_q picks operands.
  always_comb begin
    ma = '0;
    mb = '0;
    case (m_q)
      4'd0: begin ma = sy; mb = 32'(sp); end
      4'd1: begin ma = cy; mb = 32'(sp); end
      4'd2: begin ma = sy; mb = 32'(cp); end
      4'd3: begin ma = cy; mb = 32'(cp); end
      4'd4: begin ma = cy; mb = px_q; end
      4'd5: begin ma = sy; mb = pz_q; end
      4'd6: begin ma = ux_q; mb = px_q; end
      4'd7: begin ma = cp; mb = py_q; end
      4'd8: begin ma = uz_q; mb = pz_q; end
      4'd9: begin ma = bx_q; mb = px_q; end
      4'd10: begin ma = -sp; mb = py_q; end
      4'd11: begin ma = bz_q; mb = pz_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = 48'(ma) * 48'(mb);
  assign tsum = acc_q + 50'(prod);

  function automatic logic signed [15:0] r14(input logic signed [47:0] p);
    return ypvm_pkg::clamp14(36'((p + 48'sd8192) >>> 14));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      it_q <= '0;
      m_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (job_valid_i) begin
          state_q <= S_CORDIC;
          it_q <= '0;
        end
        S_CORDIC: begin
          if (32'(it_q) == CordicSteps - 1 || 32'(it_q) == ypvm_pkg::TabLen - 1) begin
            state_q <= S_MUL;
            m_q <= '0;
          end
          it_q <= it_q + 1'b1;
        end
        S_MUL: begin
          m_q <= m_q + 4'd1;
          if (m_q == 4'd3) state_q <= S_DOT;
        end
        S_DOT: begin
          m_q <= m_q + 4'd1;
          if (m_q == 4'd11) state_q <= S_DONE;
        end
        S_DONE: if (!res_valid_o || res_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic rv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else if (state_q == S_DONE && (!rv_q || res_ready_i)) rv_q <= 1'b1;
    else if (res_ready_i) rv_q <= 1'b0;
  end
  assign res_valid_o = rv_q;
  assign job_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (job_valid_i) begin
        // Fold angles into +-90 degrees; negate outputs when folded.
        nega_q <= (job_i.yaw > 16'sd16384) || (job_i.yaw < -16'sd16384);
        negb_q <= (job_i.pitch > 16'sd16384) || (job_i.pitch < -16'sd16384);
        if (job_i.yaw > 16'sd16384) za_q <= {17'(job_i.yaw) - 17'sd32768, 16'd0};
        else if (job_i.yaw < -16'sd16384) za_q <= {17'(job_i.yaw) + 17'sd32768, 16'd0};
        else za_q <= {17'(job_i.yaw), 16'd0};
        if (job_i.pitch > 16'sd16384) zb_q <= {17'(job_i.pitch) - 17'sd32768, 16'd0};
        else if (job_i.pitch < -16'sd16384) zb_q <= {17'(job_i.pitch) + 17'sd32768, 16'd0};
        else zb_q <= {17'(job_i.pitch), 16'd0};
        xa_q <= 34'(ypvm_pkg::GainQ30);
        xb_q <= 34'(ypvm_pkg::GainQ30);
        ya_q <= '0;
        yb_q <= '0;
        px_q <= job_i.px;
        py_q <= job_i.py;
        pz_q <= job_i.pz;
      end
      S_CORDIC: begin
        if (!za_q[32]) begin
          xa_q <= xa_q - dxa; ya_q <= ya_q + dya; za_q <= za_q - at;
        end else begin
          xa_q <= xa_q + dxa; ya_q <= ya_q - dya; za_q <= za_q + at;
        end
        if (!zb_q[32]) begin
          xb_q <= xb_q - dxb; yb_q <= yb_q + dyb; zb_q <= zb_q - at;
        end else begin
          xb_q <= xb_q + dxb; yb_q <= yb_q - dyb; zb_q <= zb_q + at;
        end
        acc_q <= '0;
      end
      S_MUL: begin
        case (m_q)
          4'd0: ux_q <= -r14(prod);
          4'd1: uz_q <= r14(prod);
          4'd2: bx_q <= -r14(prod);
          default: bz_q <= r14(prod);
        endcase
      end
      S_DOT: begin
        if (m_q == 4'd5 || m_q == 4'd8 || m_q == 4'd11) begin
          acc_q <= '0;
          case (m_q)
            4'd5: tr_q <= sat32(tsum);
            4'd8: tu_q <= sat32(tsum);
            default: tb_q <= sat32(tsum);
          endcase
        end else begin
          acc_q <= tsum;
        end
      end
      default: ;
    endcase
  end

  ypvm_pkg::res_t out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!rv_q || res_ready_i)) begin
      out_q <= '{rx: cy, rz: sy, ux: ux_q, uy: cp, uz: uz_q, bx: bx_q, by: -sp,
                 bz: bz_q, tr: tr_q, tu: tu_q, tb: tb_q};
    end
  end
  assign res_o = out_q;
endmodule

// ===== sv/yaw_pitch_view_matrix.sv =====
// Yaw/pitch camera view matrix.
// Input channel: push/full. An item is a transfer when push is high and full
// low; operation 0 adds the angles to the stored yaw and pitch, 1 sets them,
// pitch is clamped to +-pitch_limit, yaw wraps modulo a full turn.
// Result channel: empty/pop. While empty is low the oldest result sits on the
// outputs; it leaves on a cycle with pop high.
// pitch_limit is written with pitch_limit_we_i; write only when idle.
// Path from transfer to result: the front register, the iterative CORDIC
// (one step per cycle, yaw and pitch in parallel), 4 products and 8 dot
// terms on one shared multiplier, and the output register.
// One item is worked on at a time; a second may wait in the front register.
// The back end holds a finished result until pop; while the receiver stalls,
// the front stage keeps one item and then raises full.
// Reset clears yaw and pitch to zero, sets pitch_limit to 16199 and empties
// both stages.
module yaw_pitch_view_matrix #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               operation_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic               pitch_limit_we_i,
  input  logic [14:0]        pitch_limit_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic signed [15:0] back_x_o,
  output logic signed [15:0] back_y_o,
  output logic signed [15:0] back_z_o,
  output logic signed [31:0] trans_right_o,
  output logic signed [31:0] trans_up_o,
  output logic signed [31:0] trans_back_o
);
  logic [14:0] limit_q;
  logic job_valid, job_ready, res_valid;
  ypvm_pkg::job_t job;
  ypvm_pkg::res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= ypvm_pkg::LimitReset;
    else if (pitch_limit_we_i) limit_q <= pitch_limit_i;
  end

  ypvm_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .op_i(operation_i), .yaw_i(yaw_angle_i), .pitch_i(pitch_angle_i),
    .px_i(pos_x_i), .py_i(pos_y_i), .pz_i(pos_z_i), .limit_i(limit_q),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  ypvm_back #(.CordicSteps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .res_valid_o(res_valid), .res_ready_i(pop), .res_o(res)
  );

  assign empty = !res_valid;
  assign right_x_o = res.rx;
  assign right_z_o = res.rz;
  assign up_x_o = res.ux;
  assign up_y_o = res.uy;
  assign up_z_o = res.uz;
  assign back_x_o = res.bx;
  assign back_y_o = res.by;
  assign back_z_o = res.bz;
  assign trans_right_o = res.tr;
  assign trans_up_o = res.tu;
  assign trans_back_o = res.tb;
endmodule

// ===== sv/yaw_pitch_view_matrix_chk.sv =====
`include "yaw_pitch_view_matrix_assert.svh"
module yaw_pitch_view_matrix_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input logic signed [15:0] right_x_o,
  input logic signed [15:0] up_y_o,
  input logic signed [15:0] back_z_o
);
  `YPVM_ASSERT_IMP(a_rx_range, clk_i, rst_ni, !empty, right_x_o <= 16'sd16384 && right_x_o >= -16'sd16384)
  `YPVM_ASSERT_IMP(a_upy_range, clk_i, rst_ni, !empty, up_y_o <= 16'sd16384 && up_y_o >= -16'sd16384)
  `YPVM_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(back_z_o))
endmodule

bind yaw_pitch_view_matrix yaw_pitch_view_matrix_chk u_chk (.*);

// ===== tb/sv/yaw_pitch_view_matrix_tb.sv =====
module yaw_pitch_view_matrix_tb;

  typedef struct {
    ypvm_pkg::op_e      op;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } cam_item_t;

  typedef struct {
    logic signed [15:0] rx, rz, ux, uy, uz, bx, by, bz;
    logic signed [31:0] tr, tu, tb;
  } view_t;

  localparam int unsigned Steps = 16;
  localparam int unsigned SettleCycles = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic operation_i = 1'b0;
  logic signed [15:0] yaw_angle_i = '0;
  logic signed [15:0] pitch_angle_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic pitch_limit_we_i = 1'b0;
  logic [14:0] pitch_limit_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] right_x_o, right_z_o, up_x_o, up_y_o, up_z_o;
  logic signed [15:0] back_x_o, back_y_o, back_z_o;
  logic signed [31:0] trans_right_o, trans_up_o, trans_back_o;

  yaw_pitch_view_matrix dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cam_item_t  pending_q[$];
  view_t      expected_views_q[$];
  int         mismatches = 0;
  int         views_seen = 0;
  int         items_sent = 0;
  int         send_idle_pct = 0;
  int         pop_stall_pct = 0;
  logic [14:0] cam_limit = ypvm_pkg::LimitReset;
  logic signed [15:0] cam_yaw = '0;
  logic signed [15:0] cam_pitch = '0;
  logic full_seen = 1'b1;

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_step(int i);
    longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886,
      83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81};
    return tab[i];
  endfunction

  function automatic void rotate_angle(input longint ang, output longint s,
                                       output longint c);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = ang;
    flip = 0;
    x = 652032874;
    y = 0;
    if (a > 16384) begin
      a -= 32768; flip = 1;
    end else if (a < -16384) begin
      a += 32768; flip = 1;
    end
    z = a * 65536;
    for (int i = 0; i < Steps; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = clip(sra(x + 32768, 16), -16384, 16384);
    s = clip(sra(y + 32768, 16), -16384, 16384);
    if (flip) begin
      c = -c; s = -s;
    end
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip(sra(a * b + 8192, 14), -16384, 16384);
  endfunction

  function automatic longint neg_dot(longint ax, longint ay, longint az,
                                     longint px, longint py, longint pz);
    longint d;
    d = ax * px + ay * py + az * pz;
    return clip(sra(-d + 8192, 14), -64'sd2147483648, 64'sd2147483647);
  endfunction

  // Advance the camera state and work out the view for one accepted item.
  function automatic view_t camera_view(cam_item_t it);
    view_t v;
    longint lim, p, sy, cy, sp, cp, ux, uz, bx, bz;
    lim = cam_limit > 15'd16384 ? 16384 : longint'(cam_limit);
    if (it.op == ypvm_pkg::OP_SET) begin
      cam_yaw = it.yaw;
      p = it.pitch;
    end else begin
      cam_yaw = cam_yaw + it.yaw;
      p = longint'(cam_pitch) + longint'(it.pitch);
    end
    cam_pitch = 16'(clip(p, -lim, lim));
    rotate_angle(cam_yaw, sy, cy);
    rotate_angle(cam_pitch, sp, cp);
    ux = -qmul(sy, sp);
    uz = qmul(cy, sp);
    bx = -qmul(sy, cp);
    bz = qmul(cy, cp);
    v.rx = 16'(cy); v.rz = 16'(sy);
    v.ux = 16'(ux); v.uy = 16'(cp); v.uz = 16'(uz);
    v.bx = 16'(bx); v.by = 16'(-sp); v.bz = 16'(bz);
    v.tr = 32'(neg_dot(cy, 0, sy, it.px, it.py, it.pz));
    v.tu = 32'(neg_dot(ux, cp, uz, it.px, it.py, it.pz));
    v.tb = 32'(neg_dot(bx, -sp, bz, it.px, it.py, it.pz));
    return v;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on view %0d: %s got %0d expected %0d", views_seen, what, got, want);
    mismatches++;
  endtask

  // Driver: present the head of the pending queue, drop it on transfer.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && !full_seen) begin
        expected_views_q.push_back(camera_view(pending_q.pop_front()));
        items_sent++;
      end
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        operation_i <= pending_q[0].op;
        yaw_angle_i <= pending_q[0].yaw;
        pitch_angle_i <= pending_q[0].pitch;
        pos_x_i <= pending_q[0].px;
        pos_y_i <= pending_q[0].py;
        pos_z_i <= pending_q[0].pz;
      end else begin
        push <= 1'b0;
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Full sampled at the rising edge decides whether the push transferred.
  always @(posedge clk_i) full_seen <= full;

  // Monitor: check each popped view against the oldest expectation.
  always @(posedge clk_i) begin
    view_t w;
    if (rst_ni && pop && !empty) begin
      views_seen++;
      if (expected_views_q.size() == 0) begin
        report("unexpected view", 0, 0);
      end else begin
        w = expected_views_q.pop_front();
        if (right_x_o !== w.rx) report("right_x", right_x_o, w.rx);
        if (right_z_o !== w.rz) report("right_z", right_z_o, w.rz);
        if (up_x_o !== w.ux) report("up_x", up_x_o, w.ux);
        if (up_y_o !== w.uy) report("up_y", up_y_o, w.uy);
        if (up_z_o !== w.uz) report("up_z", up_z_o, w.uz);
        if (back_x_o !== w.bx) report("back_x", back_x_o, w.bx);
        if (back_y_o !== w.by) report("back_y", back_y_o, w.by);
        if (back_z_o !== w.bz) report("back_z", back_z_o, w.bz);
        if (trans_right_o !== w.tr) report("trans_right", trans_right_o, w.tr);
        if (trans_up_o !== w.tu) report("trans_up", trans_up_o, w.tu);
        if (trans_back_o !== w.tb) report("trans_back", trans_back_o, w.tb);
      end
    end
  end

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 65535) << 8)
                                     : -32'($urandom_range(0, 65535) << 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic cam_item_t rand_item();
    cam_item_t it;
    it.op = ypvm_pkg::op_e'($urandom_range(1));
    if (it.op == ypvm_pkg::OP_ADD && $urandom_range(3) != 0) begin
      it.yaw = 16'($signed($urandom_range(0, 4000)) - 2000);
      it.pitch = 16'($signed($urandom_range(0, 4000)) - 2000);
    end else begin
      it.yaw = 16'($urandom);
      it.pitch = 16'($urandom);
    end
    it.px = rand_pos();
    it.py = rand_pos();
    it.pz = rand_pos();
    return it;
  endfunction

  function automatic cam_item_t mk(ypvm_pkg::op_e op, int y, int p, int x, int yy, int z);
    cam_item_t it;
    it.op = op; it.yaw = 16'(y); it.pitch = 16'(p); it.px = x; it.py = yy; it.pz = z;
    return it;
  endfunction

  task automatic drain();
    wait (pending_q.size() == 0 && !push);
    wait (expected_views_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [14:0] lim);
    @(negedge clk_i);
    pitch_limit_we_i <= 1'b1;
    pitch_limit_i <= lim;
    @(negedge clk_i);
    pitch_limit_we_i <= 1'b0;
    cam_limit = lim;
  endtask

  initial begin
    logic [14:0] limits[5] = '{15'd0, 15'd16384, 15'd32767, 15'd4096, 15'd16199};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, both operations, wraps and clamps.
    pending_q.push_back(mk(ypvm_pkg::OP_SET, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ypvm_pkg::OP_SET, 32767, 32767, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff));
    pending_q.push_back(mk(ypvm_pkg::OP_SET, -32768, -32768, 32'h80000000, 32'h80000000,
                           32'h80000000));
    pending_q.push_back(mk(ypvm_pkg::OP_ADD, 32767, 32767, 65536, -65536, 65536));
    pending_q.push_back(mk(ypvm_pkg::OP_ADD, 32767, -32768, -1, 1, -1));
    pending_q.push_back(mk(ypvm_pkg::OP_SET, 16384, 16384, 32'h7fffffff, 0, 32'h80000000));
    pending_q.push_back(mk(ypvm_pkg::OP_SET, -16384, -16385, 12345, 0, 0));
    pending_q.push_back(mk(ypvm_pkg::OP_SET, 16385, 8192, 0, 32'h7fffffff, 0));
    pending_q.push_back(mk(ypvm_pkg::OP_ADD, -32768, 0, 0, 0, 32'h7fffffff));
    pending_q.push_back(mk(ypvm_pkg::OP_ADD, 0, -32768, 32'h80000000, 32'h7fffffff,
                           32'h80000000));
    pending_q.push_back(mk(ypvm_pkg::OP_SET, 8192, -8192, 32'h55555555, 32'haaaaaaaa,
                           32'h0f0f0f0f));
    pending_q.push_back(mk(ypvm_pkg::OP_ADD, 8192, 8192, 32'haaaaaaaa, 32'h55555555,
                           32'hf0f0f0f0));
    drain();
    send_idle_pct = 0;
    pop_stall_pct = 0;

    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      // A lowered limit pulls the held pitch in on the next item.
      pending_q.push_back(mk(ypvm_pkg::OP_ADD, 0, 0, 65536, 65536, 65536));
      for (int mode = 0; mode < 4; mode++) begin
        send_idle_pct = (mode == 1 || mode == 3) ? 56 : (mode == 3 ? 6 : 0);
        pop_stall_pct = (mode == 2 || mode == 3) ? 56 : 0;
        if (mode == 3) begin
          send_idle_pct = 6; pop_stall_pct = 6;
        end
        for (int k = 0; k < 54; k++) pending_q.push_back(rand_item());
        // In mode 1 hold off until every view has come back, else until all are sent.
        if (mode == 1) drain();
        else wait (pending_q.size() == 0);
      end
      drain();
    end
    send_idle_pct = 0;
    pop_stall_pct = 0;
    drain();

    $display("sent %0d camera updates over 5 pitch limits, checked %0d views",
             items_sent, views_seen);
    if (mismatches == 0 && expected_views_q.size() == 0) begin
      $display("[yaw_pitch_view_matrix] OK");
    end else begin
      $display("[yaw_pitch_view_matrix] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[yaw_pitch_view_matrix] ERROR");
    $finish;
  end

endmodule
